// ----- rtl/exprlex_pkg.sv -----
// Package with the shared types and constants of the expression lexer.
`timescale 1ns / 1ps
`default_nettype none

package exprlex_pkg;

  localparam int VALUE_BITS = 31;
  localparam int POS_OUT_BITS = 16;
  localparam logic [VALUE_BITS-1:0] INT_LIMIT = 31'h7FFF_FFFF;

  localparam logic ACT_CHAR = 1'b0;
  localparam logic ACT_END  = 1'b1;

  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_VTAB    = 8'h0B;
  localparam logic [7:0] CH_FF      = 8'h0C;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;

  typedef enum logic [2:0] {
    KIND_INT   = 3'd0,
    KIND_MINUS = 3'd1,
    KIND_PLUS  = 3'd2,
    KIND_PARL  = 3'd3,
    KIND_PARR  = 3'd4,
    KIND_ERROR = 3'd5
  } token_kind_t;

  typedef enum logic [1:0] {
    PH_LEAD   = 2'd0,
    PH_DIGITS = 2'd1,
    PH_TAIL   = 2'd2,
    PH_BAD    = 2'd3
  } scan_phase_t;

  typedef struct packed {
    token_kind_t             kind;
    logic [VALUE_BITS-1:0]   value;
    logic [POS_OUT_BITS-1:0] line;
    logic [POS_OUT_BITS-1:0] col;
    logic                    last;
  } token_t;

  typedef struct packed {
    token_t first;
    token_t second;
    logic   two;
  } bundle_t;

endpackage

`default_nettype wire

// ----- rtl/exprlex_if.sv -----
// Channel interfaces of the expression lexer: character input and token output.
`timescale 1ns / 1ps
`default_nettype none

interface exprlex_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] char_code;

  modport source (output valid, output action, output char_code, input ready);
  modport sink (input valid, input action, input char_code, output ready);
endinterface

interface exprlex_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  token_kind;
  logic [30:0] int_value;
  logic [15:0] line_number;
  logic [15:0] column_offset;
  logic        last_of_run;

  modport source (output valid, output token_kind, output int_value, output line_number,
                  output column_offset, output last_of_run, input ready);
  modport sink (input valid, input token_kind, input int_value, input line_number,
                input column_offset, input last_of_run, output ready);
endinterface

`default_nettype wire

// ----- rtl/exprlex_front.sv -----
// Front end: accepts characters, tracks the pending number and positions, builds token bundles.
`timescale 1ns / 1ps
`default_nettype none

module exprlex_front
  import exprlex_pkg::*;
#(
  parameter int POSITION_BITS = 16
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire logic    in_action,
  input  wire logic [7:0] in_char_code,
  output logic         push,
  output bundle_t      push_data,
  input  wire logic    queue_full
);

  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

  logic                     pending_r, pending_nxt;
  scan_phase_t              phase_r, phase_nxt;
  logic [VALUE_BITS-1:0]    value_r, value_nxt;
  logic                     ovf_r, ovf_nxt;
  logic [POSITION_BITS-1:0] line_r, line_nxt;
  logic [POSITION_BITS-1:0] chars_r, chars_nxt;
  logic                     failed_r, failed_nxt;

  logic                     take;
  logic                     is_digit;
  logic                     is_space;
  logic                     bad;
  logic [VALUE_BITS+3:0]    prod;
  logic [POSITION_BITS-1:0] chars_inc;
  logic [POS_OUT_BITS-1:0]  line_out;
  logic [POS_OUT_BITS-1:0]  col_inc_out;
  logic [POS_OUT_BITS-1:0]  col_cur_out;
  token_t                   num_tok;
  token_t                   op_tok;
  logic                     is_op;
  token_kind_t              op_kind;

  assign in_ready = !queue_full;
  assign take     = in_valid && in_ready;

  assign is_digit = in_char_code inside {[CH_ZERO:CH_NINE]};
  assign is_space = in_char_code inside {CH_TAB, CH_VTAB, CH_FF, CH_CR};
  assign bad      = (phase_r == PH_LEAD) || (phase_r == PH_BAD) || ovf_r;
  assign prod     = ({4'd0, value_r} << 3) + ({4'd0, value_r} << 1)
                    + {{VALUE_BITS{1'b0}}, in_char_code[3:0]};
  assign chars_inc = (chars_r != POS_MAX) ? chars_r + {{(POSITION_BITS-1){1'b0}}, 1'b1}
                                          : chars_r;
  assign line_out    = POS_OUT_BITS'(line_r);
  assign col_inc_out = POS_OUT_BITS'(chars_inc);
  assign col_cur_out = POS_OUT_BITS'(chars_r);

  always_comb begin
    is_op   = 1'b1;
    op_kind = KIND_MINUS;
    case (in_char_code)
      CH_MINUS:  op_kind = KIND_MINUS;
      CH_PLUS:   op_kind = KIND_PLUS;
      CH_LPAREN: op_kind = KIND_PARL;
      CH_RPAREN: op_kind = KIND_PARR;
      default:   is_op = 1'b0;
    endcase
  end

  always_comb begin
    pending_nxt = pending_r;
    phase_nxt   = phase_r;
    value_nxt   = value_r;
    ovf_nxt     = ovf_r;
    line_nxt    = line_r;
    chars_nxt   = chars_r;
    failed_nxt  = failed_r;
    push        = 1'b0;

    num_tok.kind  = bad ? KIND_ERROR : KIND_INT;
    num_tok.value = bad ? '0 : value_r;
    num_tok.line  = line_out;
    num_tok.col   = col_inc_out;
    num_tok.last  = 1'b0;
    op_tok.kind   = op_kind;
    op_tok.value  = '0;
    op_tok.line   = line_out;
    op_tok.col    = col_inc_out;
    op_tok.last   = 1'b1;
    push_data.first  = num_tok;
    push_data.second = op_tok;
    push_data.two    = 1'b0;

    if (take) begin
      if (in_action == ACT_END) begin
        if (!failed_r && pending_r) begin
          push = 1'b1;
          push_data.first.col  = col_cur_out;
          push_data.first.last = 1'b1;
        end
        pending_nxt = 1'b0;
        phase_nxt   = PH_LEAD;
        value_nxt   = '0;
        ovf_nxt     = 1'b0;
        line_nxt    = '0;
        chars_nxt   = '0;
        failed_nxt  = 1'b0;
      end else if (!failed_r) begin
        chars_nxt = chars_inc;
        if (is_op || in_char_code == CH_SPACE || in_char_code == CH_NEWLINE) begin
          if (pending_r && bad) begin
            push = 1'b1;
            push_data.first.last = 1'b1;
            failed_nxt = 1'b1;
          end else begin
            if (in_char_code == CH_NEWLINE && line_r != POS_MAX) begin
              line_nxt = line_r + {{(POSITION_BITS-1){1'b0}}, 1'b1};
            end
            if (pending_r) begin
              push = 1'b1;
              if (is_op) begin
                push_data.two = 1'b1;
              end else begin
                push_data.first.last = 1'b1;
              end
            end else if (is_op) begin
              push = 1'b1;
              push_data.first = op_tok;
            end
          end
          pending_nxt = 1'b0;
          phase_nxt   = PH_LEAD;
          value_nxt   = '0;
          ovf_nxt     = 1'b0;
        end else begin
          pending_nxt = 1'b1;
          case (phase_r)
            PH_LEAD: begin
              if (!is_space) begin
                phase_nxt = is_digit ? PH_DIGITS : PH_BAD;
                if (is_digit) begin
                  value_nxt = VALUE_BITS'(in_char_code[3:0]);
                end
              end
            end
            PH_DIGITS: begin
              if (!is_digit) begin
                phase_nxt = PH_TAIL;
              end else if (prod > {4'd0, INT_LIMIT}) begin
                value_nxt = INT_LIMIT;
                ovf_nxt   = 1'b1;
              end else begin
                value_nxt = prod[VALUE_BITS-1:0];
              end
            end
            default: begin
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 1'b0;
      phase_r   <= PH_LEAD;
      value_r   <= '0;
      ovf_r     <= 1'b0;
      line_r    <= '0;
      chars_r   <= '0;
      failed_r  <= 1'b0;
    end else begin
      pending_r <= pending_nxt;
      phase_r   <= phase_nxt;
      value_r   <= value_nxt;
      ovf_r     <= ovf_nxt;
      line_r    <= line_nxt;
      chars_r   <= chars_nxt;
      failed_r  <= failed_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/exprlex_queue.sv -----
// Small FIFO of token bundles between the front end and the output stage.
`timescale 1ns / 1ps
`default_nettype none

module exprlex_queue
  import exprlex_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire bundle_t push_data,
  output logic         full,
  input  wire logic    pop,
  output bundle_t      pop_data,
  output logic         empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(DEPTH - 1);

  bundle_t            slots_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push;
  logic               do_pop;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_IDX) ? '0 : wr_ptr_r + {{(PTR_W-1){1'b0}}, 1'b1};
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_IDX) ? '0 : rd_ptr_r + {{(PTR_W-1){1'b0}}, 1'b1};
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + {{(CNT_W-1){1'b0}}, 1'b1};
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - {{(CNT_W-1){1'b0}}, 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/exprlex_back.sv -----
// Output stage: unpacks bundles and presents one token per transaction from a register.
`timescale 1ns / 1ps
`default_nettype none

module exprlex_back
  import exprlex_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    queue_empty,
  input  wire bundle_t queue_data,
  output logic         pop,
  output logic         out_valid,
  input  wire logic    out_ready,
  output token_t       out_token
);

  logic   valid_r, valid_nxt;
  token_t cur_r, cur_nxt;
  logic   sec_valid_r, sec_valid_nxt;
  token_t sec_r, sec_nxt;
  logic   advance;

  assign advance   = !valid_r || out_ready;
  assign pop       = advance && !sec_valid_r && !queue_empty;
  assign out_valid = valid_r;
  assign out_token = cur_r;

  always_comb begin
    valid_nxt     = valid_r;
    cur_nxt       = cur_r;
    sec_valid_nxt = sec_valid_r;
    sec_nxt       = sec_r;
    if (advance) begin
      if (sec_valid_r) begin
        valid_nxt     = 1'b1;
        cur_nxt       = sec_r;
        sec_valid_nxt = 1'b0;
      end else if (!queue_empty) begin
        valid_nxt     = 1'b1;
        cur_nxt       = queue_data.first;
        sec_nxt       = queue_data.second;
        sec_valid_nxt = queue_data.two;
      end else begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    sec_r <= sec_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= 1'b0;
      sec_valid_r <= 1'b0;
    end else begin
      valid_r     <= valid_nxt;
      sec_valid_r <= sec_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/expression_lexer.sv -----
// Top level of the expression lexer: front end, bundle queue and output stage.
//
// The input channel carries one transaction per text byte, or an end-of-text
// transaction that flushes the pending number and clears all state. The output
// channel carries one token per transaction: integer, minus, plus, left or right
// parenthesis, or error, with its line and its 1-based column.
// A byte is taken in every cycle while the queue has room, so the input sustains
// one transaction per clock. A byte that ends a number in front of an operator
// yields two tokens, and the output register delivers one token per clock while the
// receiver is ready, which sets the sustained rate when such pairs follow each other.
// When nothing stalls, a token passes from the byte that caused it into the queue
// and then into the output register, where it appears on the output.
// When the receiver stalls, tokens gather in the queue of QUEUE_DEPTH bundles;
// input ready falls only when that queue is full.
// Synchronous reset clears the number state, the counters, the queue and the
// output register; no clearing pass follows, so the block is ready at once.
`timescale 1ns / 1ps
`default_nettype none

module expression_lexer
  import exprlex_pkg::*;
#(
  parameter int POSITION_BITS = 16,
  parameter int QUEUE_DEPTH = 4
) (
  input wire logic     clk,
  input wire logic     rst_n,
  exprlex_in_if.sink   in_chan,
  exprlex_out_if.source out_chan
);

  logic    push;
  bundle_t push_data;
  logic    queue_full;
  logic    pop;
  bundle_t pop_data;
  logic    queue_empty;
  token_t  out_token;

  exprlex_front #(
    .POSITION_BITS(POSITION_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_chan.valid),
    .in_ready     (in_chan.ready),
    .in_action    (in_chan.action),
    .in_char_code (in_chan.char_code),
    .push         (push),
    .push_data    (push_data),
    .queue_full   (queue_full)
  );

  exprlex_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (queue_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (queue_empty)
  );

  exprlex_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .queue_empty (queue_empty),
    .queue_data  (pop_data),
    .pop         (pop),
    .out_valid   (out_chan.valid),
    .out_ready   (out_chan.ready),
    .out_token   (out_token)
  );

  assign out_chan.token_kind    = out_token.kind;
  assign out_chan.int_value     = out_token.value;
  assign out_chan.line_number   = out_token.line;
  assign out_chan.column_offset = out_token.col;
  assign out_chan.last_of_run   = out_token.last;

endmodule

`default_nettype wire

// ----- rtl/exprlex_checker.sv -----
// Port-level checker of the expression lexer and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

module exprlex_checker
  import exprlex_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  out_kind,
  input wire logic [30:0] out_value,
  input wire logic        out_last
);

  // The output register is empty in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // A stalled token stays presented.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output token withdrawn while stalled");

  // Only integer tokens carry a value.
  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_INT |-> out_value == '0)
    else $error("non-integer token with nonzero value");

  // An error token always closes the results of its transaction.
  a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_ERROR |-> out_last)
    else $error("error token not marked last");

  // A token that is not last is followed at once by an operator token.
  a_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid && out_kind != KIND_INT
      && out_kind != KIND_ERROR)
    else $error("first token of a pair not followed by an operator");

endmodule

bind expression_lexer exprlex_checker u_exprlex_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_kind  (out_chan.token_kind),
  .out_value (out_chan.int_value),
  .out_last  (out_chan.last_of_run)
);

`default_nettype wire
